// ===== hw/rtl/packed_error_log_stack_core_assert.svh =====
// ----------------------------------------------------------------------------
// packed error log stack assertion macros
// shared property forms for the checker of the fault log core
// ----------------------------------------------------------------------------
`ifndef PACKED_ERROR_LOG_STACK_CORE_ASSERT_SVH
`define PACKED_ERROR_LOG_STACK_CORE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PELS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packed error log check failed");

// condition holds in the cycle after the trigger
`define PELS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packed error log check failed");

`endif

// ===== hw/rtl/pels_pkg.sv =====
// ----------------------------------------------------------------------------
// packed error log stack package
// sizes, codes and shared types of the fault log core
// ----------------------------------------------------------------------------
package pels_pkg;

	// log geometry
	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// field widths
	localparam int OP_W    = 2;
	localparam int BYTE_W  = 8;
	localparam int MS_W    = 32;
	localparam int INDEX_W = 4;
	localparam int ECNT_W  = 4;
	localparam int S_DATA_W = 64;
	localparam int M_DATA_W = 64;

	// time conversion
	localparam int DIV_W  = 16;
	localparam int MIN_W  = MS_W - DIV_W + 1;
	localparam logic [DIV_W-1:0] MS_PER_MIN = 16'd60000;

	// ms / 60000 == (ms >> 5) / 1875, taken as (ms >> 5) * ceil(2^38 / 1875) >> 38
	localparam int DIV_SHIFT = 5;
	localparam int RECIP_X_W = MS_W - DIV_SHIFT;
	localparam int RECIP_W   = 28;
	localparam int RECIP_SH  = 38;
	localparam logic [RECIP_W-1:0] RECIP = 28'd146601551;

	// entry encoding
	localparam int MARK_BIT = 7;
	localparam logic [BYTE_W-1:0] OVERFLOW_KIND = 8'd8;
	localparam logic [BYTE_W-1:0] INVALID_ID    = 8'hFF;
	localparam logic [BYTE_W-1:0] PACK_MOD_LIM  = 8'd8;
	localparam logic [BYTE_W-1:0] PACK_CODE_LIM = 8'd32;
	localparam logic [ECNT_W-1:0] ECNT_MAX      = 4'hF;

	typedef enum logic [OP_W-1:0] {
		OP_ADD,
		OP_READ,
		OP_DELETE,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		ST_SINGLE,
		ST_DOUBLE,
		ST_OVERFLOW,
		ST_DROPPED,
		ST_DELETED,
		ST_REJECTED,
		ST_DONE
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] kind;
		logic [MIN_W-1:0]  minutes;
		logic [BYTE_W-1:0] param;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            ent;
		logic              param_en;
	} mem_wr_t;

	typedef struct packed {
		logic            start;
		logic [MS_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [MIN_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/pels_mem.sv =====
// ----------------------------------------------------------------------------
// packed error log entry store
// one write port, one registered read port, per-entry valid flags
// ----------------------------------------------------------------------------
module pels_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pels_pkg::mem_wr_t         wr,
	input  logic                      clr,
	input  logic [pels_pkg::ADDR_W-1:0] rd_addr,
	output pels_pkg::entry_t          rd_data
);
	import pels_pkg::*;

	logic [BYTE_W-1:0] kind_mem  [DEPTH];
	logic [MIN_W-1:0]  min_mem   [DEPTH];
	logic [BYTE_W-1:0] param_mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	entry_t            rd_q;
	logic              rd_valid_q;

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			kind_mem[wr.addr] <= wr.ent.kind;
			min_mem[wr.addr]  <= wr.ent.minutes;
			// a marker keeps the old param, which is zero on a fresh entry
			if (wr.param_en || !valid_q[wr.addr]) begin
				param_mem[wr.addr] <= wr.param_en ? wr.ent.param : '0;
			end
		end
		rd_q.kind    <= kind_mem[rd_addr];
		rd_q.minutes <= min_mem[rd_addr];
		rd_q.param   <= param_mem[rd_addr];
	end

	// valid flags, cleared by reset and by a clear request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
			if (clr) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
		end
	end

	// an entry never written reads as zero
	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// ===== hw/rtl/pels_div.sv =====
// ----------------------------------------------------------------------------
// packed error log minute divider
// divide by the ms-per-minute constant as a registered reciprocal multiply
// ----------------------------------------------------------------------------
module pels_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pels_pkg::div_req_t req,
	output pels_pkg::div_rsp_t rsp
);
	import pels_pkg::*;

	logic [RECIP_X_W-1:0]         x_q;
	logic [MIN_W-1:0]             quo_q;
	logic                         busy_q;
	logic [RECIP_X_W+RECIP_W-1:0] prod;

	// ms / 32 times the scaled inverse of 1875
	assign prod = {{RECIP_W{1'b0}}, x_q} * {{RECIP_X_W{1'b0}}, RECIP};

	// operand capture into x_q, then the quotient registered into quo_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			quo_q  <= '0;
			busy_q <= 1'b0;
		end else if (req.start) begin
			x_q    <= req.dividend[MS_W-1:DIV_SHIFT];
			busy_q <= 1'b1;
		end else if (busy_q) begin
			quo_q  <= prod[RECIP_SH +: MIN_W];
			busy_q <= 1'b0;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== hw/rtl/packed_error_log_stack_core.sv =====
// ----------------------------------------------------------------------------
// packed error log stack core
// fault log of packed entries with add, read, delete and clear requests
// ----------------------------------------------------------------------------
// One request is worked at a time and the input is not ready until its result
// is loaded into the output register. An add takes the minute stamp from a
// reciprocal multiply, then makes one entry write for a single entry or one
// overflow marker, two for a split pair or two markers, or none when dropped,
// and then the result step; a read makes three reads of the single entry-store
// port plus a decode and multiply step; a delete makes one read and one write
// per shifted entry, or none when rejected; a clear makes a single clear step.
// The next request is taken while an earlier result still waits on the
// output; a finished result waits until the output register is free.
module packed_error_log_stack_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// module_req[7:0], code[15:8], param[23:16], now_ms[55:24], index[59:56]
	input  logic [pels_pkg::S_DATA_W-1:0] s_tdata,
	// op[1:0]
	input  logic [pels_pkg::OP_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[2:0], entry_count[6:3], module_out[14:7], code_out[22:15],
	// date_ms[54:23], param_out[62:55], notify[63]
	output logic [pels_pkg::M_DATA_W-1:0] m_tdata
);
	import pels_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_WR0,
		S_WR1,
		S_RD_SELF,
		S_RD_PREV,
		S_RD_NEXT,
		S_DECODE,
		S_DEL_CHK,
		S_DEL_STEP,
		S_DEL_WR,
		S_CLR,
		S_DONE
	} state_t;

	state_t                state_q;
	op_t                   op_q;
	logic [BYTE_W-1:0]     mod_q;
	logic [BYTE_W-1:0]     code_q;
	logic [BYTE_W-1:0]     prm_q;
	logic [INDEX_W-1:0]    idx_q;
	logic [MIN_W-1:0]      min_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      ptr_q;
	logic                  dbl_q;
	logic                  mark_q;
	logic                  prev_mark_q;
	entry_t                self_q;
	status_t               res_status_q;
	logic [BYTE_W-1:0]     res_mo_q;
	logic [BYTE_W-1:0]     res_co_q;
	logic [MS_W-1:0]       res_date_q;
	logic [BYTE_W-1:0]     res_prm_q;
	logic                  m_tvalid_q;
	logic [M_DATA_W-1:0]   m_tdata_q;

	logic                  accept;
	op_t                   in_op;
	logic [BYTE_W-1:0]     in_mod;
	logic [BYTE_W-1:0]     in_code;
	logic [BYTE_W-1:0]     in_prm;
	logic [MS_W-1:0]       in_now;
	logic [INDEX_W-1:0]    in_idx;
	logic                  dbl_w;
	logic                  full_w;
	logic                  mark_w;
	logic                  idx_ok_w;
	logic                  near_end_w;
	logic                  del_ok_w;
	logic [CNT_W-1:0]      ptr_nxt;
	logic                  step_w;
	logic [BYTE_W-1:0]     dec_mo;
	logic [BYTE_W-1:0]     dec_co;
	logic [MIN_W+DIV_W-1:0] prod;
	logic [ECNT_W-1:0]     ecnt;
	div_req_t              div_req;
	div_rsp_t              div_rsp;
	mem_wr_t               wr;
	logic                  mem_clr;
	logic [ADDR_W-1:0]     rd_addr;
	entry_t                rd_data;

	// request fields
	assign accept  = s_tvalid && s_tready;
	assign in_op   = op_t'(s_tuser);
	assign in_mod  = s_tdata[7:0];
	assign in_code = s_tdata[15:8];
	assign in_prm  = s_tdata[23:16];
	assign in_now  = s_tdata[55:24];
	assign in_idx  = s_tdata[59:56];

	// add placement decisions
	assign dbl_w  = (mod_q >= PACK_MOD_LIM) || (code_q >= PACK_CODE_LIM);
	assign full_w = 32'(cnt_q) >= 32'(DEPTH - 1);
	assign mark_w = (32'(cnt_q) >= 32'(DEPTH - 2)) ||
		((32'(cnt_q) >= 32'(DEPTH - 3)) && dbl_w);

	// index checks
	assign idx_ok_w   = 32'(idx_q) < 32'(DEPTH);
	assign near_end_w = 32'(idx_q) >= 32'(DEPTH - 2);
	assign del_ok_w   = idx_ok_w && (32'(idx_q) < 32'(cnt_q));
	assign ptr_nxt    = ptr_q + CNT_W'(1);
	assign step_w     = ptr_nxt < cnt_q;

	// read decode, next entry sits on the store output in the decode cycle
	always_comb begin
		if (!self_q.kind[MARK_BIT]) begin
			if (prev_mark_q) begin
				dec_mo = INVALID_ID;
				dec_co = INVALID_ID;
			end else begin
				dec_mo = {5'd0, self_q.kind[2:0]};
				dec_co = {3'd0, self_q.kind[7:3]};
			end
		end else begin
			dec_mo = {1'b0, self_q.kind[6:0]};
			dec_co = near_end_w ? INVALID_ID : rd_data.kind;
		end
	end

	// minutes back to ms, wraps to 32 bits
	assign prod = {{DIV_W{1'b0}}, self_q.minutes} * {{MIN_W{1'b0}}, MS_PER_MIN};

	// saturated count for the result
	assign ecnt = (32'(cnt_q) > 32'(ECNT_MAX)) ? ECNT_MAX : ECNT_W'(cnt_q);

	// divider request
	assign div_req.start    = accept && (in_op == OP_ADD);
	assign div_req.dividend = in_now;

	// entry store port steering
	always_comb begin
		rd_addr = ADDR_W'(idx_q);
		wr      = '0;
		mem_clr = 1'b0;
		case (state_q)
			S_RD_PREV: begin
				rd_addr = ADDR_W'(idx_q) - ADDR_W'(1);
			end
			S_RD_NEXT: begin
				rd_addr = ADDR_W'(idx_q) + ADDR_W'(1);
			end
			S_WR0: begin
				wr.en          = 1'b1;
				wr.addr        = cnt_q[ADDR_W-1:0];
				wr.ent.minutes = min_q;
				wr.ent.param   = prm_q;
				wr.param_en    = !mark_q;
				if (mark_q) begin
					wr.ent.kind = OVERFLOW_KIND;
				end else if (dbl_q) begin
					wr.ent.kind = {1'b1, mod_q[6:0]};
				end else begin
					wr.ent.kind = {code_q[4:0], mod_q[2:0]};
				end
			end
			S_WR1: begin
				wr.en          = 1'b1;
				wr.addr        = cnt_q[ADDR_W-1:0];
				wr.ent.minutes = min_q;
				wr.ent.param   = prm_q;
				wr.param_en    = !mark_q;
				wr.ent.kind    = mark_q ? OVERFLOW_KIND : code_q;
			end
			S_DEL_STEP: begin
				rd_addr = ptr_nxt[ADDR_W-1:0];
			end
			S_DEL_WR: begin
				wr.en       = 1'b1;
				wr.addr     = ptr_q[ADDR_W-1:0];
				wr.ent      = rd_data;
				wr.param_en = 1'b1;
			end
			S_CLR: begin
				mem_clr = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_ADD;
			mod_q        <= '0;
			code_q       <= '0;
			prm_q        <= '0;
			idx_q        <= '0;
			min_q        <= '0;
			cnt_q        <= '0;
			ptr_q        <= '0;
			dbl_q        <= 1'b0;
			mark_q       <= 1'b0;
			prev_mark_q  <= 1'b0;
			self_q       <= '0;
			res_status_q <= ST_DONE;
			res_mo_q     <= '0;
			res_co_q     <= '0;
			res_date_q   <= '0;
			res_prm_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q         <= in_op;
						mod_q        <= in_mod;
						code_q       <= in_code;
						prm_q        <= in_prm;
						idx_q        <= in_idx;
						res_status_q <= ST_DONE;
						res_mo_q     <= '0;
						res_co_q     <= '0;
						res_date_q   <= '0;
						res_prm_q    <= '0;
						case (in_op)
							OP_ADD:    state_q <= S_DIV;
							OP_READ:   state_q <= S_RD_SELF;
							OP_DELETE: state_q <= S_DEL_CHK;
							OP_CLEAR:  state_q <= S_CLR;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_DIV: begin
					if (!div_rsp.busy) begin
						min_q  <= div_rsp.quotient;
						dbl_q  <= dbl_w;
						mark_q <= mark_w;
						if (full_w) begin
							res_status_q <= ST_DROPPED;
							state_q      <= S_DONE;
						end else begin
							if (mark_w) begin
								res_status_q <= ST_OVERFLOW;
							end else if (dbl_w) begin
								res_status_q <= ST_DOUBLE;
							end else begin
								res_status_q <= ST_SINGLE;
							end
							state_q <= S_WR0;
						end
					end
				end
				S_WR0: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= dbl_q ? S_WR1 : S_DONE;
				end
				S_WR1: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_RD_SELF: begin
					state_q <= S_RD_PREV;
				end
				S_RD_PREV: begin
					self_q  <= rd_data;
					state_q <= S_RD_NEXT;
				end
				S_RD_NEXT: begin
					prev_mark_q <= (idx_q != '0) && rd_data.kind[MARK_BIT];
					state_q     <= S_DECODE;
				end
				S_DECODE: begin
					if (idx_ok_w) begin
						res_mo_q   <= dec_mo;
						res_co_q   <= dec_co;
						res_date_q <= prod[MS_W-1:0];
						res_prm_q  <= self_q.param;
					end else begin
						res_mo_q <= INVALID_ID;
						res_co_q <= INVALID_ID;
					end
					state_q <= S_DONE;
				end
				S_DEL_CHK: begin
					if (del_ok_w) begin
						ptr_q   <= CNT_W'(idx_q);
						state_q <= S_DEL_STEP;
					end else begin
						res_status_q <= ST_REJECTED;
						state_q      <= S_DONE;
					end
				end
				S_DEL_STEP: begin
					if (step_w) begin
						state_q <= S_DEL_WR;
					end else begin
						cnt_q        <= cnt_q - CNT_W'(1);
						res_status_q <= ST_DELETED;
						state_q      <= S_DONE;
					end
				end
				S_DEL_WR: begin
					ptr_q   <= ptr_nxt;
					state_q <= S_DEL_STEP;
				end
				S_CLR: begin
					cnt_q   <= '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {(op_q == OP_ADD), res_prm_q, res_date_q,
							res_co_q, res_mo_q, ecnt, res_status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// minute divider
	pels_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// entry store
	pels_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.clr     (mem_clr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

// ===== hw/rtl/pels_checker.sv =====
// ----------------------------------------------------------------------------
// packed error log stack checker
// port-level properties of the fault log core, bound to the top level
// ----------------------------------------------------------------------------
`include "packed_error_log_stack_core_assert.svh"

module pels_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pels_pkg::M_DATA_W-1:0] m_tdata
);
	import pels_pkg::*;

	// a stalled result holds
	`PELS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// one request at a time: busy right after a request is taken
	`PELS_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)

	// notify marks exactly the add results
	`PELS_ASSERT_SAME(a_notify_add, m_tvalid, m_tdata[63] == (m_tdata[2:0] <= 3'(ST_DROPPED)))

	// only read and clear results carry decode fields
	`PELS_ASSERT_SAME(a_decode_zero, m_tvalid && (m_tdata[2:0] != 3'(ST_DONE)), m_tdata[62:7] == '0)

endmodule

bind packed_error_log_stack_core pels_checker u_pels_checker (.*);
